// ===== hdl/ida_pkg.sv =====
package ida_pkg;

	localparam int ID_W   = 16;
	localparam int STAT_W = 3;
	localparam int CIDX_W = 3;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_ALLOCATED = 3'd0;
	localparam logic [STAT_W-1:0] STAT_RELEASED  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_IGNORED   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

	// request codes
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_UNIQUE = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_RESV0  = 3'd1;

	// fresh-id search result
	typedef struct packed {
		logic            done;
		logic            ok;
		logic [ID_W-1:0] id;
	} scan_t;

endpackage

// ===== hdl/id_allocator_free_list.sv =====
// Identifier allocator with a free list of released ids. One item is worked
// on at a time: in_stall is low only while the block is idle, and a finished
// result waits in an output register so the next item can be taken meanwhile.
// A release goes from idle straight to the done state. An allocate served
// from the free list passes through a read state for the registered read of
// the free-list RAM. A fresh allocate waits in the scan state while the
// reserved ids met (at most RESERVED_SLOTS) are skipped, one per cycle, in the
// fresh-id unit. The free list holds FREE_DEPTH ids in a RAM that needs no
// clearing after reset. Ids are issued fresh from 1 upward; reserved-id
// registers equal to 0 are unused. When the counter passes 65535 the
// allocate reports exhausted; a release with the list full reports full.
// Releases of id 0, or any release in unique mode, are ignored.
module id_allocator_free_list #(
	parameter int FREE_DEPTH     = 64,
	parameter int RESERVED_SLOTS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// config write port
	input  logic                         cfg_wen,
	input  logic [ida_pkg::CIDX_W-1:0]   cfg_idx,
	input  logic [ida_pkg::ID_W-1:0]     cfg_wdata,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [ida_pkg::ID_W-1:0]     release_id,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ida_pkg::ID_W-1:0]     granted_id,
	output logic [ida_pkg::STAT_W-1:0]   status
);

	localparam int PTR_W = $clog2(FREE_DEPTH);
	localparam int CNT_W = $clog2(FREE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// config registers
	logic                     unique_q;
	logic [ida_pkg::ID_W-1:0] resv_q [RESERVED_SLOTS];

	// free list pointers
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	// finished result, waiting for the output register
	logic [ida_pkg::ID_W-1:0]   res_id_q;
	logic [ida_pkg::STAT_W-1:0] res_stat_q;

	// output register
	logic                       out_valid_q;
	logic [ida_pkg::ID_W-1:0]   out_id_q;
	logic [ida_pkg::STAT_W-1:0] out_stat_q;

	logic                     accept;
	logic                     list_empty;
	logic                     list_full;
	logic                     rel_ok;
	logic                     ram_we;
	logic [ida_pkg::ID_W-1:0] ram_rdata;
	logic                     scan_start;
	ida_pkg::scan_t           scan;
	logic                     out_load;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign in_stall   = (state_q != ST_IDLE);
	assign list_empty = (count_q == '0);
	assign list_full  = (count_q == CNT_W'(FREE_DEPTH));
	assign rel_ok     = !unique_q && (release_id != '0) && !list_full;
	assign ram_we     = accept && (req_type == ida_pkg::REQ_RELEASE) && rel_ok;
	assign scan_start = accept && (req_type == ida_pkg::REQ_ALLOC) && list_empty;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign out_valid  = out_valid_q;
	assign granted_id = out_id_q;
	assign status     = out_stat_q;

	ida_ram #(
		.WIDTH(ida_pkg::ID_W),
		.DEPTH(FREE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (release_id),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	ida_fresh #(
		.RESERVED_SLOTS(RESERVED_SLOTS)
	) u_fresh (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.resv   (resv_q),
		.res    (scan)
	);

	// config writes; indexes past the implemented slots are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unique_q <= 1'b0;
			for (int i = 0; i < RESERVED_SLOTS; i++) begin
				resv_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			if (cfg_idx == ida_pkg::CFG_UNIQUE) begin
				unique_q <= cfg_wdata[0];
			end
			for (int i = 0; i < RESERVED_SLOTS; i++) begin
				if (int'(cfg_idx) == int'(ida_pkg::CFG_RESV0) + i) begin
					resv_q[i] <= cfg_wdata;
				end
			end
		end
	end

	// control: sequencer, free list pointers, output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == ida_pkg::REQ_ALLOC) begin
							if (!list_empty) begin
								// pop: RAM data shows up next cycle
								head_q  <= (head_q == PTR_W'(FREE_DEPTH - 1)) ?
									'0 : head_q + 1'b1;
								count_q <= count_q - 1'b1;
								state_q <= ST_READ;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							if (rel_ok) begin
								tail_q  <= (tail_q == PTR_W'(FREE_DEPTH - 1)) ?
									'0 : tail_q + 1'b1;
								count_q <= count_q + 1'b1;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && req_type == ida_pkg::REQ_RELEASE) begin
			res_id_q <= '0;
			if (unique_q || release_id == '0) begin
				res_stat_q <= ida_pkg::STAT_IGNORED;
			end else if (list_full) begin
				res_stat_q <= ida_pkg::STAT_FULL;
			end else begin
				res_stat_q <= ida_pkg::STAT_RELEASED;
			end
		end else if (state_q == ST_READ) begin
			res_id_q   <= ram_rdata;
			res_stat_q <= ida_pkg::STAT_ALLOCATED;
		end else if (state_q == ST_SCAN && scan.done) begin
			res_id_q   <= scan.ok ? scan.id : '0;
			res_stat_q <= scan.ok ? ida_pkg::STAT_ALLOCATED : ida_pkg::STAT_EXHAUSTED;
		end

		if (out_load) begin
			out_id_q   <= res_id_q;
			out_stat_q <= res_stat_q;
		end
	end

endmodule

// ===== hdl/ida_ram.sv =====
module ida_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/ida_fresh.sv =====
module ida_fresh #(
	parameter int RESERVED_SLOTS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [ida_pkg::ID_W-1:0] resv [RESERVED_SLOTS],
	output ida_pkg::scan_t         res
);

	logic [ida_pkg::ID_W-1:0] counter_q;
	logic [ida_pkg::ID_W:0]   cand_q;
	logic                     busy_q;
	logic                     hit;
	logic                     over;

	// candidate matches a reserved slot in use
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < RESERVED_SLOTS; i++) begin
			if (resv[i] != '0 && resv[i] == cand_q[ida_pkg::ID_W-1:0]) begin
				hit = 1'b1;
			end
		end
	end

	assign over     = cand_q[ida_pkg::ID_W];
	assign res.done = busy_q && (over || !hit);
	assign res.ok   = !over;
	assign res.id   = cand_q[ida_pkg::ID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			busy_q    <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (over) begin
				busy_q <= 1'b0;
			end else if (!hit) begin
				busy_q    <= 1'b0;
				counter_q <= cand_q[ida_pkg::ID_W-1:0];
			end
		end
	end

	// one candidate per cycle; counter is never moved back
	always_ff @(posedge clk) begin
		if (start) begin
			cand_q <= {1'b0, counter_q} + 1'b1;
		end else if (busy_q && !over && hit) begin
			cand_q <= cand_q + 1'b1;
		end
	end

endmodule

// ===== hdl/ida_checker.sv =====
module ida_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [ida_pkg::ID_W-1:0]   granted_id,
	input logic [ida_pkg::STAT_W-1:0] status
);

	// a result held back keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_id) && $stable(status))
		else $error("result changed while stalled");

	// status codes stay in range
	a_stat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ida_pkg::STAT_FULL)
		else $error("status code out of range");

	// a nonzero id goes with an allocate, and only then
	a_grant_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ida_pkg::STAT_ALLOCATED) == (granted_id != '0)))
		else $error("granted id does not match status");

	// one item at a time: the cycle after an item is taken, input is held off
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before the first finished");

endmodule

bind id_allocator_free_list ida_checker u_ida_checker (.*);
